FILE: hw/rtl/alpha_beta_track_filter_defines.svh
// assertion macros for the alpha-beta tracker checker
`ifndef ALPHA_BETA_TRACK_FILTER_DEFINES_SVH
`define ALPHA_BETA_TRACK_FILTER_DEFINES_SVH

// consequence in the cycle after the trigger
`define ABTF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("abtf port check failed");

// consequence in the same cycle as the trigger
`define ABTF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("abtf port check failed");

`endif

FILE: hw/rtl/abtf_pkg.sv
`default_nettype none

package abtf_pkg;

    localparam int POS_W   = 32;
    localparam int TIME_W  = 24;
    localparam int ALPHA_W = 31;
    localparam int BETA_W  = 32;
    localparam int CNT_W   = 10;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 2;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;
    localparam logic [IDX_W-1:0] CFG_GAIN_MODE         = 2'd2;

    localparam logic [CFG_W-1:0] PROCESS_NOISE_RST     = 32'd65536;
    localparam logic [CFG_W-1:0] MEASUREMENT_NOISE_RST = 32'd65536;
    localparam logic [CNT_W-1:0] MEMORY_COUNT_RST      = 10'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GSTART,
        S_GAIN,
        S_LSTART,
        S_LANE,
        S_OUT
    } top_state_t;

    typedef enum logic [3:0] {
        G_IDLE,
        G_TT,
        G_TTW,
        G_LDIV,
        G_LAMSQ,
        G_SQRT,
        G_RDIV,
        G_RR,
        G_DD,
        G_MK,
        G_ADIV,
        G_BDIV,
        G_DONE
    } gain_state_t;

    typedef enum logic [2:0] {
        L_IDLE,
        L_PMUL,
        L_PRED,
        L_CMUL,
        L_CFIN,
        L_DIV,
        L_DONE
    } lane_state_t;

    typedef struct packed {
        logic start;
        logic mode;
    } gain_ctrl_t;

    typedef struct packed {
        logic start;
        logic upd;
    } lane_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/abtf_mult.sv
`default_nettype none

// 64 x 64 multiplier, one 16 bit digit of b per cycle
module abtf_mult
    import abtf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [63:0]  a,
    input  wire logic [63:0]  b,
    output logic              done,
    output logic [127:0]      prod
);

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [127:0] acc_reg;
    logic [1:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [79:0]  pp;

    assign pp = a_reg * b_reg[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + ({48'b0, pp} << {cnt_reg, 4'b0});
            b_reg   <= b_reg >> 16;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/abtf_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module abtf_div
    import abtf_pkg::*;
#(
    parameter int NW = 110,
    parameter int DW = 64
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quot
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;

    assign rem_sh = {rem_reg, num_reg[NW-1]};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!diff[DW])
            begin
                rem_reg <= diff[DW-1:0];
                num_reg <= {num_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DW-1:0];
                num_reg <= {num_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/abtf_sqrt.sv
`default_nettype none

// floor square root, two radicand bits per cycle
module abtf_sqrt
    import abtf_pkg::*;
#(
    parameter int RW = 122
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [RW-1:0] rad,
    output logic               done,
    output logic [RW/2-1:0]    root
);

    localparam int QW = RW / 2;
    localparam int CW = $clog2(QW + 1);

    logic [RW-1:0] rad_reg;
    logic [QW-1:0] root_reg;
    logic [QW+1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [QW+3:0] rem_sh;
    logic [QW+3:0] trial;
    logic [QW+3:0] diff;

    assign rem_sh = {rem_reg, rad_reg[RW-1:RW-2]};
    assign trial  = {2'b0, root_reg, 2'b01};
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= rad_reg << 2;
            if (!diff[QW+3])
            begin
                rem_reg  <= diff[QW+1:0];
                root_reg <= {root_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[QW+1:0];
                root_reg <= {root_reg[QW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/abtf_gain.sv
`default_nettype none

// gain sequencer: steady-state or growing-memory alpha and beta
module abtf_gain
    import abtf_pkg::*;
#(
    parameter int MEMORY_LIMIT = 100,
    parameter int FRAC_BITS    = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gain_ctrl_t         ctrl,
    input  wire logic [TIME_W-1:0]  step_time,
    input  wire logic [CFG_W-1:0]   pnoise,
    input  wire logic [CFG_W-1:0]   mnoise,
    output logic                    done,
    output logic [ALPHA_W-1:0]      alpha,
    output logic [BETA_W-1:0]       beta
);

    localparam int LNW = 110;
    localparam int LDW = 64;
    localparam int SRW = 122;

    localparam logic [ALPHA_W-1:0] ONE30      = 31'h4000_0000;
    localparam logic [60:0]        LAMBDA_MAX = 61'd1 << 60;
    localparam logic [63:0]        EIGHT30    = 64'd1 << 33;
    localparam logic [62:0]        FOUR30     = 63'd1 << 32;
    localparam logic [62:0]        TWO62      = 63'd1 << 62;
    localparam logic [41:0]        SIX30      = 42'd6 << 30;

    gain_state_t state_reg, state_next;
    logic        issue_reg;

    logic [CNT_W-1:0]   cnt_reg;
    logic [60:0]        lam_reg;
    logic [ALPHA_W-1:0] r_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [BETA_W-1:0]  beta_reg;

    logic             mul_start, mul_done;
    logic [63:0]      mul_a, mul_b;
    logic [127:0]     mul_prod;
    logic             div_start, div_done;
    logic [LNW-1:0]   div_num, div_quot;
    logic [LDW-1:0]   div_den;
    logic             sq_start, sq_done;
    logic [SRW/2-1:0] sq_root;

    logic [CFG_W-1:0]   v_eff;
    logic [LNW-1:0]     lam_sh;
    logic [62:0]        r_den;
    logic [62:0]        r_num;
    logic [ALPHA_W-1:0] d1;
    logic [20:0]        m_val;
    logic [11:0]        k4p2;

    assign v_eff  = (mnoise == '0) ? 32'd1 : mnoise;
    assign lam_sh = div_quot >> (2 * FRAC_BITS);
    assign r_den  = 63'(lam_reg) + FOUR30 + 63'(sq_root);
    assign r_num  = TWO62 + (r_den >> 1);
    assign d1     = ONE30 - r_reg;
    assign m_val  = mul_prod[20:0];
    assign k4p2   = {cnt_reg, 2'b10};

    abtf_mult u_mult (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    abtf_div #(.NW(LNW), .DW(LDW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    abtf_sqrt #(.RW(SRW)) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .rad   (mul_prod[SRW-1:0]),
        .done  (sq_done),
        .root  (sq_root)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            G_IDLE, G_DONE:
                if (ctrl.start)
                    state_next = ctrl.mode ? G_MK : G_TT;
            G_TT:    if (mul_done) state_next = G_TTW;
            G_TTW:   if (mul_done) state_next = G_LDIV;
            G_LDIV:  if (div_done) state_next = G_LAMSQ;
            G_LAMSQ: if (mul_done) state_next = G_SQRT;
            G_SQRT:  if (sq_done)  state_next = G_RDIV;
            G_RDIV:  if (div_done) state_next = G_RR;
            G_RR:    if (mul_done) state_next = G_DD;
            G_DD:    if (mul_done) state_next = G_DONE;
            G_MK:    if (mul_done) state_next = G_ADIV;
            G_ADIV:  if (div_done) state_next = G_BDIV;
            G_BDIV:  if (div_done) state_next = G_DONE;
            default: state_next = G_IDLE;
        endcase
    end

    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        sq_start  = 1'b0;
        unique case (state_reg)
            G_TT:
            begin
                mul_start = issue_reg;
                mul_a     = 64'(step_time);
                mul_b     = 64'(step_time);
            end
            G_TTW:
            begin
                mul_start = issue_reg;
                mul_a     = mul_prod[63:0];
                mul_b     = 64'(pnoise);
            end
            G_LDIV:
            begin
                div_start = issue_reg;
                div_num   = {mul_prod[79:0], 30'b0};
                div_den   = 64'(v_eff);
            end
            G_LAMSQ:
            begin
                mul_start = issue_reg;
                mul_a     = 64'(lam_reg) + EIGHT30;
                mul_b     = 64'(lam_reg);
            end
            G_SQRT:
                sq_start = issue_reg;
            G_RDIV:
            begin
                div_start = issue_reg;
                div_num   = LNW'(r_num);
                div_den   = 64'(r_den);
            end
            G_RR:
            begin
                mul_start = issue_reg;
                mul_a     = 64'(r_reg);
                mul_b     = 64'(r_reg);
            end
            G_DD:
            begin
                mul_start = issue_reg;
                mul_a     = 64'(d1);
                mul_b     = 64'(d1);
            end
            G_MK:
            begin
                mul_start = issue_reg;
                mul_a     = 64'(cnt_reg) + 64'd1;
                mul_b     = 64'(cnt_reg) + 64'd2;
            end
            G_ADIV:
            begin
                div_start = issue_reg;
                div_num   = LNW'({k4p2, 30'b0}) + LNW'(m_val >> 1);
                div_den   = 64'(m_val);
            end
            G_BDIV:
            begin
                div_start = issue_reg;
                div_num   = LNW'(SIX30) + LNW'(m_val >> 1);
                div_den   = 64'(m_val);
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
            issue_reg <= 1'b0;
            cnt_reg   <= MEMORY_COUNT_RST;
        end
        else
        begin
            state_reg <= state_next;
            issue_reg <= (state_next != state_reg);
            // count steps before use and stops at the limit
            if ((state_reg == G_IDLE || state_reg == G_DONE) && ctrl.start && ctrl.mode)
            begin
                if (cnt_reg < CNT_W'(MEMORY_LIMIT))
                    cnt_reg <= cnt_reg + 1'b1;
                else
                    cnt_reg <= CNT_W'(MEMORY_LIMIT);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == G_LDIV && div_done)
            lam_reg <= (lam_sh > LNW'(LAMBDA_MAX)) ? LAMBDA_MAX : lam_sh[60:0];
        if (state_reg == G_RDIV && div_done)
            r_reg <= (div_quot > LNW'(ONE30)) ? ONE30 : div_quot[ALPHA_W-1:0];
        if (state_reg == G_RR && mul_done)
            alpha_reg <= ONE30 - (mul_prod[60:30] + 31'(mul_prod[29]));
        if (state_reg == G_DD && mul_done)
            beta_reg <= mul_prod[60:29] + 32'(mul_prod[28]);
        if (state_reg == G_ADIV && div_done)
            alpha_reg <= (div_quot > LNW'(ONE30)) ? ONE30 : div_quot[ALPHA_W-1:0];
        if (state_reg == G_BDIV && div_done)
            beta_reg <= div_quot[BETA_W-1:0];
    end

    assign done  = (state_reg == G_DONE);
    assign alpha = alpha_reg;
    assign beta  = beta_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/abtf_lane.sv
`default_nettype none

// one axis: predict, residual, position and velocity correction
module abtf_lane
    import abtf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lane_ctrl_t         ctrl,
    input  wire logic [TIME_W-1:0]  step_time,
    input  wire logic [ALPHA_W-1:0] alpha,
    input  wire logic [BETA_W-1:0]  beta,
    input  wire logic [POS_W-1:0]   px,
    input  wire logic [POS_W-1:0]   pv,
    input  wire logic [POS_W-1:0]   meas,
    output logic                    done,
    output logic [POS_W-1:0]        nx,
    output logic [POS_W-1:0]        nv
);

    localparam int DDW = TIME_W + 30 - FRAC_BITS;
    localparam int VNW = 65;
    localparam logic [33:0] CV_MAX = 34'd1 << 33;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'h7fff_ffff;
        else if (v < -64'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    lane_state_t state_reg, state_next;

    logic [POS_W-1:0]   px_reg, pv_reg, meas_reg;
    logic [TIME_W-1:0]  t_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [BETA_W-1:0]  beta_reg;
    logic               upd_reg;
    logic [55:0]        pvt_reg;
    logic [POS_W-1:0]   xp_reg;
    logic [63:0]        pa_reg, pb_reg;
    logic               neg_reg;
    logic [POS_W-1:0]   nx_reg, nv_reg;

    logic [31:0]    pv_mag;
    logic [56:0]    m_round;
    logic [63:0]    m64, px64, pv64, xp64, xp_sum;
    logic [33:0]    rk, rk_mag;
    logic [34:0]    cx;
    logic [63:0]    cx64, nx_sum;
    logic [DDW-1:0] dd;
    logic           div_start, div_done;
    logic [VNW-1:0] div_quot;
    logic [33:0]    cv;
    logic [63:0]    cv64, nv_sum;

    assign pv_mag  = pv_reg[31] ? (~pv_reg + 32'd1) : pv_reg;
    assign m_round = 57'(pvt_reg >> FRAC_BITS) + 57'(pvt_reg[FRAC_BITS-1]);
    assign m64     = 64'(m_round);
    assign px64    = {{32{px_reg[31]}}, px_reg};
    assign pv64    = {{32{pv_reg[31]}}, pv_reg};
    assign xp64    = {{32{xp_reg[31]}}, xp_reg};
    assign xp_sum  = px64 + (pv_reg[31] ? (~m64 + 64'd1) : m64);

    assign rk     = {{2{meas_reg[31]}}, meas_reg} - {{2{xp_reg[31]}}, xp_reg};
    assign rk_mag = rk[33] ? (~rk + 34'd1) : rk;

    assign cx     = 35'(pa_reg[63:30]) + 35'(pa_reg[29]);
    assign cx64   = 64'(cx);
    assign nx_sum = xp64 + (neg_reg ? (~cx64 + 64'd1) : cx64);

    assign dd     = {t_reg, {(30 - FRAC_BITS){1'b0}}};
    assign cv     = (div_quot > VNW'(CV_MAX)) ? CV_MAX : div_quot[33:0];
    assign cv64   = 64'(cv);
    assign nv_sum = pv64 + (neg_reg ? (~cv64 + 64'd1) : cv64);

    abtf_div #(.NW(VNW), .DW(DDW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (VNW'(pb_reg) + VNW'(dd >> 1)),
        .den   (dd),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE, L_DONE:
                if (ctrl.start) state_next = L_PMUL;
            L_PMUL: state_next = L_PRED;
            L_PRED: state_next = upd_reg ? L_CMUL : L_DONE;
            L_CMUL: state_next = L_CFIN;
            L_CFIN: state_next = L_DIV;
            L_DIV:  if (div_done) state_next = L_DONE;
            default: state_next = L_IDLE;
        endcase
    end

    always_comb
    begin
        div_start = (state_reg == L_CFIN);
        done      = (state_reg == L_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= L_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            L_IDLE, L_DONE:
                if (ctrl.start)
                begin
                    px_reg    <= px;
                    pv_reg    <= pv;
                    meas_reg  <= meas;
                    t_reg     <= step_time;
                    alpha_reg <= alpha;
                    beta_reg  <= beta;
                    upd_reg   <= ctrl.upd;
                end
            L_PMUL:
                pvt_reg <= {24'b0, pv_mag} * {32'b0, t_reg};
            L_PRED:
            begin
                xp_reg <= sat32(xp_sum);
                if (!upd_reg)
                begin
                    nx_reg <= sat32(xp_sum);
                    nv_reg <= pv_reg;
                end
            end
            L_CMUL:
            begin
                neg_reg <= rk[33];
                pa_reg  <= 64'(rk_mag[32:0]) * 64'(alpha_reg);
                pb_reg  <= 64'(rk_mag[32:0]) * 64'(beta_reg);
            end
            L_CFIN:
                nx_reg <= sat32(nx_sum);
            L_DIV:
                if (div_done) nv_reg <= sat32(nv_sum);
            default:
                nv_reg <= nv_reg;
        endcase
    end

    assign nx = nx_reg;
    assign nv = nv_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/alpha_beta_track_filter.sv
// Two-axis alpha-beta tracker. One transfer in carries the previous x/y position and velocity,
// the measured positions, the step time and a measurement flag; one transfer out carries the
// new positions and velocities (signed Q16.16, saturated) and a time error flag. One item is
// worked at a time. An update in gain mode 0 runs as follows: the gain sequencer runs
// a 110-step divide for lambda, a 61-step square root and a second 110-step divide, plus
// five 4-step multiplies, and then both axis lanes run a 65-step velocity divide side by
// side. An update in gain mode 1 runs two 110-step divides for the growing-memory gains,
// then the lanes. A predict-only item, or one with a zero step time, skips the gain
// sequencer and the lane divide. A new item is taken while the previous result still waits
// at the output register. Configuration writes take effect at once and must come while idle.
`default_nettype none

module alpha_beta_track_filter
    import abtf_pkg::*;
#(
    parameter int MEMORY_LIMIT = 100,
    parameter int FRAC_BITS    = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input channel
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [POS_W-1:0]  prev_x,
    input  wire logic [POS_W-1:0]  prev_vx,
    input  wire logic [POS_W-1:0]  meas_x,
    input  wire logic [POS_W-1:0]  prev_y,
    input  wire logic [POS_W-1:0]  prev_vy,
    input  wire logic [POS_W-1:0]  meas_y,
    input  wire logic [TIME_W-1:0] step_time,
    input  wire logic              has_measurement,
    // output channel
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [POS_W-1:0]       next_x,
    output logic [POS_W-1:0]       next_vx,
    output logic [POS_W-1:0]       next_y,
    output logic [POS_W-1:0]       next_vy,
    output logic                   time_error,
    // configuration write port
    input  wire logic              cfg_we,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    top_state_t state_reg, state_next;

    // configuration registers
    logic [CFG_W-1:0] pnoise_reg;
    logic [CFG_W-1:0] mnoise_reg;
    logic             gmode_reg;

    // captured item
    logic [POS_W-1:0]  px_reg, pvx_reg, mx_reg;
    logic [POS_W-1:0]  py_reg, pvy_reg, my_reg;
    logic [TIME_W-1:0] t_reg;
    logic              upd_reg;
    logic              err_reg;

    // output register, merges the two lanes
    logic             out_valid_reg;
    logic [POS_W-1:0] nx_out_reg, nvx_out_reg, ny_out_reg, nvy_out_reg;
    logic             terr_out_reg;

    logic               in_xfer;
    logic               out_load;
    gain_ctrl_t         gctrl;
    lane_ctrl_t         lctrl;
    logic               gain_done;
    logic [ALPHA_W-1:0] alpha;
    logic [BETA_W-1:0]  beta;
    logic               lx_done, ly_done;
    logic [POS_W-1:0]   lx_nx, lx_nv, ly_nx, ly_nv;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    // result moves out once the output slot is empty or being emptied
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    assign gctrl.start = (state_reg == S_GSTART);
    assign gctrl.mode  = gmode_reg;
    assign lctrl.start = (state_reg == S_LSTART);
    assign lctrl.upd   = upd_reg;

    abtf_gain #(.MEMORY_LIMIT(MEMORY_LIMIT), .FRAC_BITS(FRAC_BITS)) u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (gctrl),
        .step_time (t_reg),
        .pnoise    (pnoise_reg),
        .mnoise    (mnoise_reg),
        .done      (gain_done),
        .alpha     (alpha),
        .beta      (beta)
    );

    // x lane
    abtf_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (lctrl),
        .step_time (t_reg),
        .alpha     (alpha),
        .beta      (beta),
        .px        (px_reg),
        .pv        (pvx_reg),
        .meas      (mx_reg),
        .done      (lx_done),
        .nx        (lx_nx),
        .nv        (lx_nv)
    );

    // y lane
    abtf_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (lctrl),
        .step_time (t_reg),
        .alpha     (alpha),
        .beta      (beta),
        .px        (py_reg),
        .pv        (pvy_reg),
        .meas      (my_reg),
        .done      (ly_done),
        .nx        (ly_nx),
        .nv        (ly_nv)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_xfer)
                    // gains only needed for a real update
                    state_next = (has_measurement && step_time != '0) ? S_GSTART : S_LSTART;
            S_GSTART: state_next = S_GAIN;
            S_GAIN:   if (gain_done) state_next = S_LSTART;
            S_LSTART: state_next = S_LANE;
            S_LANE:   if (lx_done && ly_done) state_next = S_OUT;
            S_OUT:    if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pnoise_reg    <= PROCESS_NOISE_RST;
            mnoise_reg    <= MEASUREMENT_NOISE_RST;
            gmode_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            // writes beyond the register list are dropped
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PROCESS_NOISE:     pnoise_reg <= cfg_data;
                    CFG_MEASUREMENT_NOISE: mnoise_reg <= cfg_data;
                    CFG_GAIN_MODE:         gmode_reg  <= cfg_data[0];
                    default:               gmode_reg  <= gmode_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            px_reg  <= prev_x;
            pvx_reg <= prev_vx;
            mx_reg  <= meas_x;
            py_reg  <= prev_y;
            pvy_reg <= prev_vy;
            my_reg  <= meas_y;
            t_reg   <= step_time;
            upd_reg <= has_measurement && (step_time != '0);
            err_reg <= has_measurement && (step_time == '0);
        end
        if (out_load)
        begin
            nx_out_reg   <= lx_nx;
            nvx_out_reg  <= lx_nv;
            ny_out_reg   <= ly_nx;
            nvy_out_reg  <= ly_nv;
            terr_out_reg <= err_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign next_x     = nx_out_reg;
    assign next_vx    = nvx_out_reg;
    assign next_y     = ny_out_reg;
    assign next_vy    = nvy_out_reg;
    assign time_error = terr_out_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/abtf_checker.sv
`default_nettype none
`include "alpha_beta_track_filter_defines.svh"

// port-level checks on the tracker
module abtf_checker
    import abtf_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic [POS_W-1:0]  prev_x,
    input wire logic [POS_W-1:0]  prev_vx,
    input wire logic [POS_W-1:0]  meas_x,
    input wire logic [POS_W-1:0]  prev_y,
    input wire logic [POS_W-1:0]  prev_vy,
    input wire logic [POS_W-1:0]  meas_y,
    input wire logic [TIME_W-1:0] step_time,
    input wire logic              has_measurement,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [POS_W-1:0]  next_x,
    input wire logic [POS_W-1:0]  next_vx,
    input wire logic [POS_W-1:0]  next_y,
    input wire logic [POS_W-1:0]  next_vy,
    input wire logic              time_error,
    input wire logic              cfg_we,
    input wire logic [IDX_W-1:0]  cfg_index,
    input wire logic [CFG_W-1:0]  cfg_data
);

    // stalled result stays offered
    `ABTF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    // stalled result keeps its payload
    `ABTF_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(next_x) && $stable(next_vx) && $stable(next_y) && $stable(next_vy) && $stable(time_error))
    // one item at a time: a transfer in is followed by a busy period
    `ABTF_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready ##1 !in_ready)
    // a new result only comes out of a busy period
    `ABTF_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(!in_ready))

endmodule

bind alpha_beta_track_filter abtf_checker u_abtf_checker (.*);

`default_nettype wire
